// File: rtl/plwm_pkg.sv
// Package for the port load window monitor: item structs, result action codes,
// controller states, register indexes and reset values.
// No dependencies; the monitor and the testbench import it.
package plwm_pkg;

    localparam int SAMPLE_W    = 27;
    localparam int WIN_LEN_W   = 5;
    localparam int THR_W       = 27;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 27;
    localparam int SUM_OUT_W   = 31;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 5'd15;
    localparam logic [THR_W-1:0]     THRESHOLD_RST  = 27'd1200000;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_WAIT     = 3'd1,
        ACT_LOAD     = 3'd2,
        ACT_DISABLE  = 3'd3,
        ACT_REDETECT = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        port_enabled;
        logic [2:0]  port_index;
        logic [15:0] voltage_mv;
        logic [10:0] current_ma;
    } t_in_item;

    typedef struct packed {
        t_action                action;
        logic [2:0]             result_port;
        logic [SUM_OUT_W-1:0]   window_sum;
        logic [COUNT_OUT_W-1:0] sample_count;
    } t_out_item;

endpackage

// File: rtl/plwm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the per-port sample rings of the load window monitor.
module plwm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/poe_port_load_window_monitor.sv
// Load window monitor for the ports of a PoE power source (top level).
// Depends on plwm_pkg and plwm_ram.
// Throughput: one item at a time; no new item is taken until the last result is registered.
// An enabled port writes the sample, does one RAM read per window entry, flushes the pipeline
// and decides; a disabled port skips reads and flush, an out-of-range port the write as well.
// The single RAM read port sets the summation time. Reset: synchronous, active low. After reset
// the ring RAM is swept to zero, one entry per cycle, and no item is taken until it is done.
module poe_port_load_window_monitor #(
    parameter int NUM_PORTS  = 8,
    parameter int MAX_WINDOW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  plwm_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output plwm_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [plwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import plwm_pkg::*;

    localparam int DEPTH = NUM_PORTS * MAX_WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int XW    = (CW > WIN_LEN_W) ? CW : WIN_LEN_W;
    localparam int PIW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int SW    = SAMPLE_W + CW;
    localparam int LW    = THR_W + CW;

    // Configuration registers.
    logic [WIN_LEN_W-1:0] r_window_len;
    logic [THR_W-1:0]     r_thr;

    // Per-port ring state.
    logic [PW-1:0]        r_wpos [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_wrapped;
    logic [NUM_PORTS-1:0] r_seen;

    // Controller.
    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    // Item context.
    logic                r_en;
    logic                r_skip;
    logic [2:0]          r_port;
    logic [PIW-1:0]      r_pidx;
    logic [AW-1:0]       r_base;
    logic [PW-1:0]       r_pos;
    logic                r_wrap_old;
    logic                r_seen_old;
    logic [CW-1:0]       r_len;
    logic [CW-1:0]       r_count;
    logic [SAMPLE_W-1:0] r_sample;
    logic [LW-1:0]       r_limit;
    logic [SW-1:0]       r_sum;
    logic [CW-1:0]       r_idx;
    logic                r_acc_vld;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out_data;

    // Control from the state machine.
    logic in_ready;
    logic clr_we;
    logic smp_we;
    logic rd_en;
    logic done;

    logic                 in_fire;
    logic                 out_free;
    logic                 in_range;
    logic [PIW+2:0]       port_x;
    logic [PIW-1:0]       in_pidx;
    logic [XW-1:0]        len_x;
    logic [CW-1:0]        eff_len;
    logic [PW:0]          next_pos;
    logic                 wrap;
    logic [PW-1:0]        new_pos;
    logic                 below;
    t_action              action;
    logic [AW-1:0]        ram_waddr;
    logic [SAMPLE_W-1:0]  ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic [SW+SUM_OUT_W-1:0]  sum_x;
    logic [CW+COUNT_OUT_W-1:0] cnt_x;

    assign in_fire  = i_in_valid && in_ready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = (32'(i_in_data.port_index) < 32'(NUM_PORTS));
    assign port_x   = (PIW + 3)'(i_in_data.port_index);
    assign in_pidx  = port_x[PIW-1:0];

    // A window length of zero counts as one; lengths above the ring size are clamped.
    always_comb begin
        len_x = XW'(r_window_len);
        if (r_window_len == '0) begin
            eff_len = CW'(1);
        end else if (len_x > XW'(MAX_WINDOW)) begin
            eff_len = CW'(MAX_WINDOW);
        end else begin
            eff_len = CW'(len_x);
        end
    end

    assign next_pos = (PW + 1)'(r_pos) + (PW + 1)'(1);
    assign wrap     = (32'(next_pos) >= 32'(r_len));
    assign new_pos  = wrap ? '0 : next_pos[PW-1:0];
    assign below    = (r_sum < r_limit);

    always_comb begin
        if (r_skip) begin
            action = ACT_NONE;
        end else if (r_en) begin
            if (below && r_wrap_old && r_seen_old) begin
                action = ACT_DISABLE;
            end else if (!below) begin
                action = ACT_LOAD;
            end else begin
                action = ACT_WAIT;
            end
        end else begin
            action = wrap ? ACT_REDETECT : ACT_NONE;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr_addr) == DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_range ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                n_state = r_en ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                if (r_idx == r_len - CW'(1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State machine outputs.
    always_comb begin
        in_ready = 1'b0;
        clr_we   = 1'b0;
        smp_we   = 1'b0;
        rd_en    = 1'b0;
        done     = 1'b0;
        unique case (r_state)
            ST_CLEAR: clr_we   = 1'b1;
            ST_IDLE:  in_ready = 1'b1;
            ST_WRITE: smp_we   = 1'b1;
            ST_READ:  rd_en    = 1'b1;
            ST_FLUSH: ;
            ST_DONE:  done     = out_free;
            default: ;
        endcase
    end

    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RST;
            r_thr        <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_LEN: r_window_len <= i_cfg_data[WIN_LEN_W-1:0];
                REG_THRESHOLD:  r_thr        <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-port ring position and flags, updated when the item's result is handed over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_wpos[p] <= '0;
            end
            r_wrapped <= '0;
            r_seen    <= '0;
        end else if (done && !r_skip) begin
            r_wpos[r_pidx] <= new_pos;
            if (wrap) begin
                r_wrapped[r_pidx] <= r_en;
            end
            if (action == ACT_LOAD) begin
                r_seen[r_pidx] <= 1'b1;
            end
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_en       <= i_in_data.port_enabled;
            r_skip     <= !in_range;
            r_port     <= i_in_data.port_index;
            r_pidx     <= in_pidx;
            r_base     <= AW'(32'(in_pidx) * MAX_WINDOW);
            r_pos      <= r_wpos[in_pidx];
            r_wrap_old <= r_wrapped[in_pidx];
            r_seen_old <= r_seen[in_pidx];
            r_len      <= eff_len;
            r_count    <= r_wrapped[in_pidx] ? eff_len
                                             : CW'((PW + 1)'(r_wpos[in_pidx]) + (PW + 1)'(1));
            r_sample   <= SAMPLE_W'(i_in_data.voltage_mv) * SAMPLE_W'(i_in_data.current_ma);
            r_sum      <= '0;
            r_limit    <= '0;
        end
        if (smp_we) begin
            r_limit <= LW'(r_thr) * LW'(r_count);
            r_idx   <= '0;
        end
        if (rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
        // Read data arrives in the cycle after its address was issued.
        if (r_acc_vld) begin
            r_sum <= r_sum + SW'(ram_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= rd_en;
        end
    end

    assign ram_waddr = clr_we ? r_clr_addr : r_base + AW'(r_pos);
    assign ram_wdata = clr_we ? '0 : r_sample;
    assign ram_raddr = r_base + AW'(r_idx);

    plwm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (clr_we || smp_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sum_x = (SW + SUM_OUT_W)'(r_sum);
    assign cnt_x = (CW + COUNT_OUT_W)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data.action      <= action;
            r_out_data.result_port <= r_port;
            if (r_en && !r_skip) begin
                r_out_data.window_sum   <= sum_x[SUM_OUT_W-1:0];
                r_out_data.sample_count <= cnt_x[COUNT_OUT_W-1:0];
            end else begin
                r_out_data.window_sum   <= '0;
                r_out_data.sample_count <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: test/testbench.sv
// Self-checking testbench for poe_port_load_window_monitor.
// It predicts every result item from its own copy of the sample rings and flags per port.
// Depends on plwm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
    import plwm_pkg::*;

    localparam int N_PORTS   = 8;
    localparam int RING_LEN  = 16;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL_WAIT = 40;

    bit i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid = 1'b0;
    t_in_item in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic o_in_stall;
    logic o_out_valid;
    t_out_item o_out_data;

    poe_port_load_window_monitor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Model of the block: configuration, sample rings and per-port flags.
    logic [WIN_LEN_W-1:0] win_len_cfg = WINDOW_LEN_RST;
    logic [THR_W-1:0]     thr_cfg     = THRESHOLD_RST;
    logic [SAMPLE_W-1:0]  ring_uw [N_PORTS][RING_LEN];
    logic [3:0]           wr_pos [N_PORTS];
    bit                   wrapped [N_PORTS];
    bit                   loaded [N_PORTS];

    // Stimulus shaping per port.
    bit heavy [N_PORTS];
    bit port_off [N_PORTS];

    t_in_item  samples_pending[$];
    t_out_item results_due[$];
    t_out_item want;

    int n_queued = 0;
    int n_taken = 0;
    int n_done = 0;
    int err_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_cnt = 0;
    bit in_taken = 1'b0;

    initial begin
        for (int p = 0; p < N_PORTS; p++) begin
            for (int i = 0; i < RING_LEN; i++) ring_uw[p][i] = '0;
            wr_pos[p] = '0;
            wrapped[p] = 1'b0;
            loaded[p] = 1'b0;
            heavy[p] = 1'b0;
            port_off[p] = 1'b0;
        end
    end

    function automatic t_out_item predict_window(t_in_item s);
        t_out_item r;
        int unsigned len;
        int unsigned pos;
        int unsigned count;
        logic [63:0] sum;
        logic [63:0] limit;
        begin
            r = '0;
            r.action = ACT_NONE;
            r.result_port = s.port_index;
            len = (win_len_cfg == 0) ? 1 : (win_len_cfg > RING_LEN) ? RING_LEN
                                                                    : 32'(win_len_cfg);
            pos = 32'(wr_pos[s.port_index]);
            ring_uw[s.port_index][pos] = SAMPLE_W'(s.voltage_mv) * SAMPLE_W'(s.current_ma);
            pos = pos + 1;
            sum = '0;
            count = 0;
            if (s.port_enabled) begin
                for (int i = 0; i < len; i++) sum = sum + 64'(ring_uw[s.port_index][i]);
                count = wrapped[s.port_index] ? len : pos;
                limit = 64'(thr_cfg) * 64'(count);
                // A port that once had a load and whose full window fell below the
                // threshold is switched off.
                if (sum < limit && wrapped[s.port_index] && loaded[s.port_index]) begin
                    r.action = ACT_DISABLE;
                end else if (sum >= limit) begin
                    loaded[s.port_index] = 1'b1;
                    r.action = ACT_LOAD;
                end else begin
                    r.action = ACT_WAIT;
                end
                if (pos >= len) begin
                    pos = 0;
                    wrapped[s.port_index] = 1'b1;
                end
            end else if (pos >= len) begin
                pos = 0;
                wrapped[s.port_index] = 1'b0;
                r.action = ACT_REDETECT;
            end
            wr_pos[s.port_index] = pos[3:0];
            r.window_sum = sum[SUM_OUT_W-1:0];
            r.sample_count = count[COUNT_OUT_W-1:0];
            return r;
        end
    endfunction

    // Sender: a new item is offered only when the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_data <= samples_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here and started on request.
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req != hold_ack) begin
            hold_cnt <= HOLD_LEN;
            hold_ack <= hold_req;
        end
    end

    always @(negedge i_clk) begin
        out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                results_due.push_back(predict_window(in_data));
                n_taken++;
            end
            if (o_out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result item with nothing expected: port %0d action %0d",
                           o_out_data.result_port, o_out_data.action);
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    n_done++;
                    if (o_out_data.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, o_out_data.action);
                        err_count++;
                    end
                    if (o_out_data.result_port !== want.result_port) begin
                        $error("result_port: expected %0d, got %0d",
                               want.result_port, o_out_data.result_port);
                        err_count++;
                    end
                    if (o_out_data.window_sum !== want.window_sum) begin
                        $error("window_sum: expected %0d, got %0d",
                               want.window_sum, o_out_data.window_sum);
                        err_count++;
                    end
                    if (o_out_data.sample_count !== want.sample_count) begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, o_out_data.sample_count);
                        err_count++;
                    end
                end
            end
        end
    end

    task automatic push_sample(input bit en, input int port, input int mv, input int ma);
        t_in_item s;
        begin
            s.port_enabled = en;
            s.port_index = port[2:0];
            s.voltage_mv = mv[15:0];
            s.current_ma = ma[10:0];
            samples_pending.push_back(s);
            n_queued++;
        end
    endtask

    // Waits until every queued item has been taken and answered.
    task automatic drain();
        wait (n_taken == n_queued && n_done == n_taken);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_WINDOW_LEN) win_len_cfg = val[WIN_LEN_W-1:0];
        else thr_cfg = val[THR_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Ports drift between loaded, idle and switched-off spells so that windows fill,
    // wrap and get disabled; one item in ten is plain noise.
    task automatic random_samples(input int n);
        int p;
        bit en;
        for (int k = 0; k < n; k++) begin
            p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            if ($urandom_range(0, 11) == 0) heavy[p] = ~heavy[p];
            if ($urandom_range(0, 19) == 0) port_off[p] = ~port_off[p];
            en = port_off[p] ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 14) != 0);
            if ($urandom_range(0, 9) == 0)
                push_sample(1'($urandom_range(0, 1)), p, $urandom_range(0, 65535),
                            $urandom_range(0, 2047));
            else
                push_sample(en, p, $urandom_range(44000, 57000),
                            heavy[p] ? $urandom_range(30, 700) : $urandom_range(0, 25));
        end
    endtask

    int win_list [8] = '{4, 16, 1, 8, 31, 0, 15, 12};
    int thr_list [8] = '{1200000, 30000000, 134217727, 0, 6000000, 2500000, 1200000, 9000000};

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes of power and the exact threshold edge.
        push_sample(1'b1, 0, 65535, 2047);
        push_sample(1'b1, 1, 0, 0);
        push_sample(1'b0, 2, $urandom_range(0, 65535), $urandom_range(0, 2047));
        push_sample(1'b1, 7, 48000, 25);
        push_sample(1'b1, 6, 48000, 24);
        drain();

        // Short window: load, wrap, drop below threshold, disable, then re-detection.
        set_reg(REG_WINDOW_LEN, 2);
        set_reg(REG_THRESHOLD, 1000);
        push_sample(1'b1, 3, 1000, 1);
        push_sample(1'b1, 3, 0, 0);
        push_sample(1'b1, 3, 0, 0);
        push_sample(1'b0, 3, 0, 0);
        push_sample(1'b0, 3, 0, 0);
        push_sample(1'b1, 3, 0, 0);
        drain();

        // A zero window length acts as one; zero threshold always sees a load.
        set_reg(REG_WINDOW_LEN, 0);
        set_reg(REG_THRESHOLD, 0);
        push_sample(1'b1, 4, 0, 0);
        push_sample(1'b0, 4, 65535, 2047);
        drain();

        // Oversized window clamps to the ring size; top threshold is never reached.
        set_reg(REG_WINDOW_LEN, 31);
        set_reg(REG_THRESHOLD, 27'h7FFFFFF);
        push_sample(1'b1, 5, 65535, 2047);
        push_sample(1'b1, 5, 65535, 2047);
        push_sample(1'b1, 5, 32768, 1024);
        drain();

        // Window shortened below the port's write position wraps at once.
        set_reg(REG_WINDOW_LEN, 1);
        push_sample(1'b1, 5, 65535, 2047);
        push_sample(1'b0, 5, 1, 1);
        drain();

        for (int seg = 0; seg < 8; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            set_reg(REG_WINDOW_LEN, CFG_DATA_W'(win_list[seg]));
            set_reg(REG_THRESHOLD, CFG_DATA_W'(thr_list[seg]));
            if (seg == 1) hold_req++;
            if (seg == 3) begin
                random_samples(80);
                drain();
                random_samples(85);
            end else begin
                random_samples(165);
            end
            drain();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/plwm_pkg.sv
rtl/plwm_ram.sv
rtl/poe_port_load_window_monitor.sv
test/testbench.sv
